@@ src/constant_fold_engine_macros.svh @@
// Assertion macros shared by the constant folding engine RTL.
`ifndef CONSTANT_FOLD_ENGINE_MACROS_SVH
`define CONSTANT_FOLD_ENGINE_MACROS_SVH

// Condition that must hold at every clock edge out of reset.
`define CFE_ASSERT(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// Condition that must hold in the cycle after a trigger.
`define CFE_ASSERT_NEXT(label, trig, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cond)) \
    else $error(msg);

`endif

@@ src/cfe_pkg.sv @@
// Types and constants of the constant folding engine.
package cfe_pkg;

  localparam int VregSlots = 1024;
  localparam int IdxW      = $clog2(VregSlots);

  localparam logic [1:0] KindNone = 2'd0;
  localparam logic [1:0] KindReg  = 2'd1;
  localparam logic [1:0] KindImm  = 2'd2;

  localparam logic [4:0] OpAdd     = 5'd0;
  localparam logic [4:0] OpSub     = 5'd1;
  localparam logic [4:0] OpMul     = 5'd2;
  localparam logic [4:0] OpDiv     = 5'd3;
  localparam logic [4:0] OpMod     = 5'd4;
  localparam logic [4:0] OpAnd     = 5'd5;
  localparam logic [4:0] OpOr      = 5'd6;
  localparam logic [4:0] OpXor     = 5'd7;
  localparam logic [4:0] OpShl     = 5'd8;
  localparam logic [4:0] OpAsr     = 5'd9;
  localparam logic [4:0] OpLsr     = 5'd10;
  localparam logic [4:0] OpEq      = 5'd11;
  localparam logic [4:0] OpNe      = 5'd12;
  localparam logic [4:0] OpLt      = 5'd13;
  localparam logic [4:0] OpLe      = 5'd14;
  localparam logic [4:0] OpUlt     = 5'd15;
  localparam logic [4:0] OpUle     = 5'd16;
  localparam logic [4:0] OpLea     = 5'd17;
  localparam logic [4:0] OpLoadImm = 5'd18;

  localparam logic OperWhole = 1'b0;
  localparam logic OperExtra = 1'b1;

  typedef struct packed {
    logic               operation;
    logic               new_function;
    logic [4:0]         opcode;
    logic               dst_valid;
    logic [9:0]         dst_reg;
    logic               wide;
    logic [1:0]         a_kind;
    logic [9:0]         a_reg;
    logic signed [63:0] a_imm;
    logic [1:0]         b_kind;
    logic [9:0]         b_reg;
    logic signed [63:0] b_imm;
  } in_item_t;

  typedef struct packed {
    logic               folded;
    logic [1:0]         out_a_kind;
    logic [9:0]         out_a_reg;
    logic signed [63:0] out_a_imm;
    logic [1:0]         out_b_kind;
    logic [9:0]         out_b_reg;
    logic signed [63:0] out_b_imm;
  } out_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [9:0]  rnum;
    logic [63:0] imm;
  } opnd_t;

endpackage

@@ src/constant_fold_engine.sv @@
// Top level of the constant folding engine: constant table, sequencer and shared adder.

// One instruction is handled at a time. The constant table is a memory of flag and value
// words with one read and one write port; the two source lookups read it in consecutive
// cycles. A plain instruction passes through SRdA, SRdB, SSub, SDec and SDone before its
// result is registered, and the next item is taken once the sequencer is idle again; add,
// logic, shifts and compares also pass through SExec for evaluation and SWb for the table
// update; mul runs 64 shift-add steps on the shared 64-bit adder and div/mod run 64
// restoring steps plus sign fixes on the same adder. A finished result waits until the
// output register is free, and no new item is taken meanwhile. After reset, and for every
// item with new_function set, a clearing pass writes all 1024 table entries, one per cycle,
// before work goes on; no item is taken during the pass after reset.
`include "constant_fold_engine_macros.svh"

module constant_fold_engine (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  cfe_pkg::in_item_t   in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output cfe_pkg::out_item_t  out_item_o
);
  import cfe_pkg::*;

  localparam logic [3:0] SIdle  = 4'd0;
  localparam logic [3:0] SClear = 4'd1;
  localparam logic [3:0] SRdA   = 4'd2;
  localparam logic [3:0] SRdB   = 4'd3;
  localparam logic [3:0] SSub   = 4'd4;
  localparam logic [3:0] SDec   = 4'd5;
  localparam logic [3:0] SExec  = 4'd6;
  localparam logic [3:0] SMul   = 4'd7;
  localparam logic [3:0] SNegA  = 4'd8;
  localparam logic [3:0] SNegB  = 4'd9;
  localparam logic [3:0] SDiv   = 4'd10;
  localparam logic [3:0] SFix   = 4'd11;
  localparam logic [3:0] SWb    = 4'd12;
  localparam logic [3:0] SDone  = 4'd13;

  localparam logic [63:0] Sign64 = {1'b1, 63'd0};

  logic [3:0]      state_q, state_d;
  logic [IdxW-1:0] cnt_q, cnt_d;
  logic            clr_ret_q, clr_ret_d;
  logic            out_valid_q, out_valid_d;
  out_item_t       out_q, out_d;
  in_item_t        it_q, it_d;
  opnd_t           a_q, a_d, b_q, b_d;
  logic            folded_q, folded_d;
  logic [63:0]     acc_q, acc_d, opx_q, opx_d, opy_q, opy_d, res_q, res_d;

  logic [64:0]     mem [VregSlots];
  logic [64:0]     rd_q;
  logic [IdxW-1:0] rd_addr, wr_addr;
  logic            wr_en;
  logic [64:0]     wr_data;

  logic [63:0] add_x, add_y;
  logic        add_ci;
  logic [64:0] add_s;

  logic        tracked, foldable;
  logic [5:0]  sh;
  logic [63:0] rem_sh, quo_sel, narrow_a;

  function automatic opnd_t subst(logic [1:0] kind, logic [9:0] rnum, logic [63:0] imm,
                                  logic [64:0] word);
    opnd_t o;
    o = '0;
    case (kind)
      KindReg: begin
        if ((32'(rnum) < VregSlots) && word[64]) begin
          o.kind = KindImm;
          o.imm  = word[63:0];
        end else begin
          o.kind = KindReg;
          o.rnum = rnum;
        end
      end
      KindImm: begin
        o.kind = KindImm;
        o.imm  = imm;
      end
      default: o = '0;
    endcase
    return o;
  endfunction

  assign add_s = {1'b0, add_x} + {1'b0, add_y} + 65'(add_ci);

  assign tracked  = it_q.dst_valid && (32'(it_q.dst_reg) < VregSlots);
  assign foldable = (it_q.opcode <= OpLea) &&
                    !(((it_q.opcode == OpDiv) || (it_q.opcode == OpMod)) && (b_q.imm == '0));
  assign sh       = it_q.wide ? b_q.imm[5:0] : {1'b0, b_q.imm[4:0]};
  assign narrow_a = {{32{a_q.imm[31]}}, a_q.imm[31:0]};
  assign rem_sh   = {acc_q[62:0], opx_q[63]};
  assign quo_sel  = (it_q.opcode == OpDiv) ? opx_q : acc_q;

  // Shared adder operand selection.
  always_comb begin
    add_x  = '0;
    add_y  = '0;
    add_ci = 1'b0;
    case (state_q)
      SExec: begin
        case (it_q.opcode)
          OpSub, OpUlt: begin
            add_x = a_q.imm; add_y = ~b_q.imm; add_ci = 1'b1;
          end
          OpUle: begin
            add_x = b_q.imm; add_y = ~a_q.imm; add_ci = 1'b1;
          end
          OpLt: begin
            add_x = a_q.imm ^ Sign64; add_y = ~(b_q.imm ^ Sign64); add_ci = 1'b1;
          end
          OpLe: begin
            add_x = b_q.imm ^ Sign64; add_y = ~(a_q.imm ^ Sign64); add_ci = 1'b1;
          end
          default: begin
            add_x = a_q.imm; add_y = b_q.imm;
          end
        endcase
      end
      SMul: begin
        add_x = acc_q;
        add_y = opy_q[0] ? opx_q : '0;
      end
      SNegA: begin
        add_y = ~a_q.imm; add_ci = 1'b1;
      end
      SNegB: begin
        add_y = ~b_q.imm; add_ci = 1'b1;
      end
      SDiv: begin
        add_x = rem_sh; add_y = ~opy_q; add_ci = 1'b1;
      end
      SFix: begin
        add_y = ~quo_sel; add_ci = 1'b1;
      end
      default: begin
        add_x = '0;
      end
    endcase
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    clr_ret_d   = clr_ret_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    it_d        = it_q;
    a_d         = a_q;
    b_d         = b_q;
    folded_d    = folded_q;
    acc_d       = acc_q;
    opx_d       = opx_q;
    opy_d       = opy_q;
    res_d       = res_q;
    rd_addr     = '0;
    wr_en       = 1'b0;
    wr_addr     = it_q.dst_reg[IdxW-1:0];
    wr_data     = '0;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      SIdle: begin
        if (in_valid_i) begin
          it_d      = in_item_i;
          folded_d  = 1'b0;
          cnt_d     = '0;
          clr_ret_d = 1'b1;
          state_d   = in_item_i.new_function ? SClear : SRdA;
        end
      end
      SClear: begin
        wr_en   = 1'b1;
        wr_addr = cnt_q;
        cnt_d   = cnt_q + 1'b1;
        if (cnt_q == IdxW'(VregSlots - 1)) begin
          state_d = clr_ret_q ? SRdA : SIdle;
        end
      end
      SRdA: begin
        rd_addr = it_q.a_reg[IdxW-1:0];
        state_d = SRdB;
      end
      SRdB: begin
        rd_addr = it_q.b_reg[IdxW-1:0];
        a_d     = subst(it_q.a_kind, it_q.a_reg, it_q.a_imm, rd_q);
        state_d = SSub;
      end
      SSub: begin
        if (it_q.operation == OperExtra) begin
          // The extra operand passes through unsubstituted.
          b_d = subst(it_q.b_kind, it_q.b_reg, it_q.b_imm, '0);
        end else begin
          b_d = subst(it_q.b_kind, it_q.b_reg, it_q.b_imm, rd_q);
        end
        state_d = SDec;
      end
      SDec: begin
        state_d = SDone;
        if (it_q.operation == OperWhole) begin
          if (it_q.opcode == OpLoadImm) begin
            wr_en   = tracked;
            wr_data = {1'b1, (a_q.kind == KindImm) ? a_q.imm : 64'(it_q.a_imm)};
          end else if (tracked && (a_q.kind == KindImm) && (b_q.kind == KindImm) &&
                       foldable) begin
            cnt_d = '0;
            acc_d = '0;
            opx_d = a_q.imm;
            opy_d = b_q.imm;
            case (it_q.opcode)
              OpMul:        state_d = SMul;
              OpDiv, OpMod: state_d = SNegA;
              default:      state_d = SExec;
            endcase
          end else begin
            wr_en   = tracked;
            wr_data = '0;
          end
        end
      end
      SExec: begin
        case (it_q.opcode)
          OpAnd: res_d = a_q.imm & b_q.imm;
          OpOr:  res_d = a_q.imm | b_q.imm;
          OpXor: res_d = a_q.imm ^ b_q.imm;
          OpShl: begin
            res_d = a_q.imm << sh;
            if (!it_q.wide) begin
              res_d = {{32{res_d[31]}}, res_d[31:0]};
            end
          end
          OpAsr: res_d = it_q.wide ? 64'($signed(a_q.imm) >>> sh)
                                   : 64'($signed(narrow_a) >>> sh);
          OpLsr: res_d = it_q.wide ? (a_q.imm >> sh) : ({32'd0, a_q.imm[31:0]} >> sh);
          OpEq:  res_d = 64'(a_q.imm == b_q.imm);
          OpNe:  res_d = 64'(a_q.imm != b_q.imm);
          OpLt, OpUlt: res_d = 64'(!add_s[64]);
          OpLe, OpUle: res_d = 64'(add_s[64]);
          default: res_d = add_s[63:0];
        endcase
        state_d = SWb;
      end
      SMul: begin
        acc_d = add_s[63:0];
        opx_d = opx_q << 1;
        opy_d = opy_q >> 1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q[5:0] == 6'd63) begin
          res_d   = add_s[63:0];
          state_d = SWb;
        end
      end
      SNegA: begin
        opx_d   = a_q.imm[63] ? add_s[63:0] : a_q.imm;
        state_d = SNegB;
      end
      SNegB: begin
        opy_d   = b_q.imm[63] ? add_s[63:0] : b_q.imm;
        state_d = SDiv;
      end
      SDiv: begin
        // Restoring step: the dividend shifts out of opx_q as quotient bits shift in.
        acc_d = add_s[64] ? add_s[63:0] : rem_sh;
        opx_d = {opx_q[62:0], add_s[64]};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q[5:0] == 6'd63) begin
          state_d = SFix;
        end
      end
      SFix: begin
        if (it_q.opcode == OpDiv) begin
          res_d = (a_q.imm[63] ^ b_q.imm[63]) ? add_s[63:0] : quo_sel;
        end else begin
          res_d = a_q.imm[63] ? add_s[63:0] : quo_sel;
        end
        state_d = SWb;
      end
      SWb: begin
        wr_en    = 1'b1;
        wr_data  = {1'b1, res_q};
        folded_d = 1'b1;
        a_d      = '{kind: KindImm, rnum: '0, imm: res_q};
        b_d      = '0;
        state_d  = SDone;
      end
      SDone: begin
        if (!out_valid_q) begin
          out_valid_d = 1'b1;
          out_d = '{folded: folded_q,
                    out_a_kind: a_q.kind, out_a_reg: a_q.rnum, out_a_imm: a_q.imm,
                    out_b_kind: b_q.kind, out_b_reg: b_q.rnum, out_b_imm: b_q.imm};
          state_d = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SClear;
      cnt_q       <= '0;
      clr_ret_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      clr_ret_q   <= clr_ret_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q    <= out_d;
    it_q     <= it_d;
    a_q      <= a_d;
    b_q      <= b_d;
    folded_q <= folded_d;
    acc_q    <= acc_d;
    opx_q    <= opx_d;
    opy_q    <= opy_d;
    res_q    <= res_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q <= mem[rd_addr];
  end

  assign in_stall_o  = (state_q != SIdle);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  `CFE_ASSERT_NEXT(a_busy_after_take, in_valid_i && !in_stall_o, in_stall_o, "took a second item")
  `CFE_ASSERT(a_folded_form, !(out_valid_o && out_item_o.folded) || (out_item_o.out_a_kind == KindImm && out_item_o.out_b_kind == KindNone), "bad folded result")
  `CFE_ASSERT(a_write_states, !wr_en || state_q == SClear || state_q == SDec || state_q == SWb, "table written out of turn")
  `CFE_ASSERT(a_div_nonzero, state_q != SDiv || opy_q != '0, "division by zero entered")
  `CFE_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o, "result dropped")

endmodule

@@ sim/constant_fold_engine_tb.sv @@
// Self-checking testbench of the constant folding engine with a built-in constant table.
module constant_fold_engine_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import cfe_pkg::*;

  localparam logic [4:0] OpOther = 5'd19;
  localparam int CycleLimit = 2_500_000;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  in_item_t   in_item_i = '0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  out_item_t  out_item_o;

  constant_fold_engine dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_item_i,
    .out_valid_o, .out_stall_i, .out_item_o
  );

  always #5 clk_i = ~clk_i;

  // Predictor state: a shadow of the constant table.
  logic        known_mark [VregSlots];
  logic [63:0] known_word [VregSlots];
  out_item_t   pending_folds [$];
  int          errors = 0;
  int          cycles = 0;
  int          burst_left = 0;
  bit          hold_off = 1'b0;
  bit          long_hold = 1'b0;

  function automatic logic [63:0] sext32(logic [63:0] v);
    return {{32{v[31]}}, v[31:0]};
  endfunction

  // Computes a foldable opcode; returns 0 when it does not fold.
  function automatic bit fold_value(logic [4:0] op, logic [63:0] a, logic [63:0] b,
                                    logic wide, output logic [63:0] r);
    logic [5:0]  sh;
    logic [63:0] ua, ub, q;
    sh = wide ? b[5:0] : {1'b0, b[4:0]};
    ua = a[63] ? -a : a;
    ub = b[63] ? -b : b;
    r = '0;
    case (op)
      OpAdd, OpLea: r = a + b;
      OpSub: r = a - b;
      OpMul: r = a * b;
      OpDiv: begin
        if (b == 0) return 0;
        q = ua / ub;
        r = (a[63] != b[63]) ? -q : q;
      end
      OpMod: begin
        if (b == 0) return 0;
        q = ua % ub;
        r = a[63] ? -q : q;
      end
      OpAnd: r = a & b;
      OpOr: r = a | b;
      OpXor: r = a ^ b;
      OpShl: r = wide ? (a << sh) : sext32(a << sh);
      OpAsr: r = wide ? 64'($signed(a) >>> sh) : 64'($signed(sext32(a)) >>> sh);
      OpLsr: r = wide ? (a >> sh) : ({32'd0, a[31:0]} >> sh);
      OpEq: r = 64'(a == b);
      OpNe: r = 64'(a != b);
      OpLt: r = 64'($signed(a) < $signed(b));
      OpLe: r = 64'($signed(a) <= $signed(b));
      OpUlt: r = 64'(a < b);
      OpUle: r = 64'(a <= b);
      default: return 0;
    endcase
    return 1;
  endfunction

  function automatic opnd_t lookup_source(logic [1:0] kind, logic [9:0] rn, logic [63:0] imm);
    opnd_t o;
    o = '0;
    if (kind == KindReg) begin
      if (known_mark[rn]) begin
        o.kind = KindImm;
        o.imm = known_word[rn];
      end else begin
        o.kind = KindReg;
        o.rnum = rn;
      end
    end else if (kind == KindImm) begin
      o.kind = KindImm;
      o.imm = imm;
    end
    return o;
  endfunction

  // Applies one instruction to the shadow table and queues its expected result.
  task automatic predict_fold(in_item_t it);
    opnd_t     a, b;
    out_item_t r;
    logic [63:0] v;
    if (it.new_function) foreach (known_mark[i]) known_mark[i] = 1'b0;
    a = lookup_source(it.a_kind, it.a_reg, it.a_imm);
    r = '0;
    if (it.operation == OperExtra) begin
      b = '0;
      b.kind = (it.b_kind == 2'd3) ? KindNone : it.b_kind;
      if (b.kind == KindReg) b.rnum = it.b_reg;
      if (b.kind == KindImm) b.imm = it.b_imm;
    end else begin
      b = lookup_source(it.b_kind, it.b_reg, it.b_imm);
      if (it.dst_valid) begin
        if (it.opcode == OpLoadImm) begin
          known_mark[it.dst_reg] = 1'b1;
          known_word[it.dst_reg] = (a.kind == KindImm) ? a.imm : it.a_imm;
        end else if (a.kind == KindImm && b.kind == KindImm &&
                     fold_value(it.opcode, a.imm, b.imm, it.wide, v)) begin
          known_mark[it.dst_reg] = 1'b1;
          known_word[it.dst_reg] = v;
          r.folded = 1'b1;
          a = '0;
          a.kind = KindImm;
          a.imm = v;
          b = '0;
        end else begin
          known_mark[it.dst_reg] = 1'b0;
        end
      end
    end
    r.out_a_kind = a.kind;
    r.out_a_reg = a.rnum;
    r.out_a_imm = a.imm;
    r.out_b_kind = b.kind;
    r.out_b_reg = b.rnum;
    r.out_b_imm = b.imm;
    pending_folds.push_back(r);
  endtask

  // Offers one item, honoring burst gaps, and predicts it once transferred.
  task automatic send_instr(in_item_t it, bit gaps = 1'b1);
    @(negedge clk_i);
    if (gaps) begin
      if (burst_left == 0) begin
        repeat ($urandom_range(0, 2) == 0 ? $urandom_range(1, 12) : 0) @(negedge clk_i);
        burst_left = $urandom_range(1, 20);
      end
      burst_left--;
    end
    in_item_i <= it;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    predict_fold(it);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  task automatic drain_results();
    while (pending_folds.size() != 0) @(negedge clk_i);
  endtask

  // Register numbers mostly come from a small pool so that references hit often.
  function automatic logic [9:0] pick_reg();
    int r;
    r = $urandom_range(0, 9);
    if (r < 7) return 10'($urandom_range(0, 15));
    return 10'($urandom);
  endfunction

  function automatic logic [63:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 64'h8000_0000_0000_0000;
      1: return 64'hFFFF_FFFF_FFFF_FFFF;
      2: return '0;
      3: return 64'($urandom_range(0, 70));
      4: return 64'h7FFF_FFFF_FFFF_FFFF;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic in_item_t random_instr(bit noise);
    in_item_t it;
    it = '0;
    it.operation = ($urandom_range(0, 9) == 0);
    it.new_function = ($urandom_range(0, 60) == 0);
    it.opcode = noise ? 5'($urandom) : 5'($urandom_range(0, 19));
    it.dst_valid = ($urandom_range(0, 7) != 0);
    it.dst_reg = pick_reg();
    it.wide = 1'($urandom_range(0, 1));
    it.a_kind = noise ? 2'($urandom) : 2'($urandom_range(1, 2));
    it.b_kind = noise ? 2'($urandom) : 2'($urandom_range(1, 2));
    it.a_reg = pick_reg();
    it.b_reg = pick_reg();
    it.a_imm = pick_value();
    it.b_imm = pick_value();
    return it;
  endfunction

  function automatic in_item_t mk(logic [4:0] op, logic [1:0] ak, logic [63:0] ai,
                                  logic [1:0] bk, logic [63:0] bi, logic [9:0] d,
                                  logic wide);
    in_item_t it;
    it = '0;
    it.opcode = op;
    it.dst_valid = 1'b1;
    it.dst_reg = d;
    it.wide = wide;
    it.a_kind = ak;
    it.a_imm = ai;
    it.a_reg = ai[9:0];
    it.b_kind = bk;
    it.b_imm = bi;
    it.b_reg = bi[9:0];
    return it;
  endfunction

  task automatic test_directed_ops();
    in_item_t it;
    send_instr(mk(OpLoadImm, KindImm, 64'h8000_0000_0000_0000, KindNone, 64'd0, 10'd1,
                  1'b1));
    send_instr(mk(OpLoadImm, KindImm, 64'hFFFF_FFFF_FFFF_FFFF, KindNone, 64'd0, 10'd2,
                  1'b1));
    // Most negative divided by minus one, through both table lookups.
    send_instr(mk(OpDiv, KindReg, 64'd1, KindReg, 64'd2, 10'd3, 1'b1));
    send_instr(mk(OpMod, KindReg, 64'd1, KindReg, 64'd2, 10'd4, 1'b1));
    // Zero divisor does not fold.
    send_instr(mk(OpDiv, KindImm, 64'd7, KindImm, 64'd0, 10'd5, 1'b1));
    send_instr(mk(OpMod, KindImm, -64'sd7, KindImm, 64'd0, 10'd6, 1'b0));
    for (int op = 0; op <= int'(OpOther); op++)
      send_instr(mk(5'(op), KindImm, 64'hFFFF_FFFF_8000_0001, KindImm, 64'd33, 10'd1023,
                    op[0]));
    // Load-immediate from a non-constant register takes the raw immediate.
    it = mk(OpLoadImm, KindReg, 64'h0000_0000_0000_0005, KindNone, 64'd0, 10'd7, 1'b0);
    it.a_imm = 64'h1234_5678_9ABC_DEF0;
    it.a_reg = 10'd5;
    send_instr(it);
    // Extra operand only, with an undefined second kind.
    it = mk(OpAdd, KindReg, 64'd7, 2'd3, 64'd1, 10'd8, 1'b0);
    it.operation = OperExtra;
    send_instr(it);
    it.new_function = 1'b1;
    it.a_kind = 2'd3;
    send_instr(it);
    drain_results();
  endtask

  task automatic test_random_stream(int n);
    in_item_t it;
    for (int i = 0; i < n; i++) begin
      it = random_instr($urandom_range(0, 7) == 0);
      send_instr(it);
    end
  endtask

  task automatic test_backpressure();
    in_item_t it;
    long_hold = 1'b1;
    for (int i = 0; i < 12; i++) begin
      it = random_instr(1'b0);
      it.new_function = 1'b0;
      send_instr(it, 1'b0);
    end
    drain_results();
  endtask

  // Receiver stall pattern: periodic phases plus a long hold on request.
  always @(negedge clk_i) begin
    if (long_hold) begin
      out_stall_i <= 1'b1;
      repeat (300) @(negedge clk_i);
      long_hold = 1'b0;
      out_stall_i <= 1'b0;
    end else if (hold_off) begin
      out_stall_i <= ((cycles % 23) < 9) ^ ($urandom_range(0, 5) == 0);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    out_item_t exp_r;
    cycles++;
    if (cycles > CycleLimit) begin
      $display("constant_fold_engine test failed");
      $finish;
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_folds.size() == 0) begin
        errors++;
        $display("%0t: unexpected result %h", $realtime, out_item_o);
      end else begin
        exp_r = pending_folds.pop_front();
        if (out_item_o !== exp_r) begin
          errors++;
          $display("%0t: mismatch expected folded=%0b a=%0d/%0d/%h b=%0d/%0d/%h",
                   $realtime, exp_r.folded, exp_r.out_a_kind, exp_r.out_a_reg,
                   exp_r.out_a_imm, exp_r.out_b_kind, exp_r.out_b_reg, exp_r.out_b_imm);
          $display("%0t:   actual   folded=%0b a=%0d/%0d/%h b=%0d/%0d/%h",
                   $realtime, out_item_o.folded, out_item_o.out_a_kind,
                   out_item_o.out_a_reg, out_item_o.out_a_imm, out_item_o.out_b_kind,
                   out_item_o.out_b_reg, out_item_o.out_b_imm);
        end
      end
    end
  end

  initial begin
    foreach (known_mark[i]) begin
      known_mark[i] = 1'b0;
      known_word[i] = '0;
    end
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed_ops();
    hold_off = 1'b1;
    test_random_stream(700);
    test_backpressure();
    test_random_stream(720);
    drain_results();
    repeat (100) @(negedge clk_i);
    if (errors == 0 && pending_folds.size() == 0) begin
      $display("constant_fold_engine test passed");
    end else begin
      $display("constant_fold_engine test failed");
    end
    $finish;
  end

endmodule

@@ constant_fold_engine.f @@
+incdir+src
src/cfe_pkg.sv
src/constant_fold_engine.sv
sim/constant_fold_engine_tb.sv
